>>> hw/rtl/bpnl_pkg.sv
// Shared types and constants for the bound-pruned node list.
// No dependencies.
package bpnl_pkg;

  localparam int DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    FN_PUSH  = 3'd0,
    FN_POP   = 3'd1,
    FN_READ  = 3'd2,
    FN_ERASE = 3'd3,
    FN_PRUNE = 3'd4,
    FN_MIN   = 3'd5,
    FN_CLEAR = 3'd6,
    FN_NOP   = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] key;
    logic [15:0]        handle;
    logic [5:0]         index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         entry_count;
    logic signed [31:0] found_key;
    logic [15:0]        found_handle;
    logic [5:0]         found_index;
    logic [6:0]         removed_count;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the input word, start read of slot 0 / target
    logic walk;   // one scan step
    logic finish; // build result word
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan;      // operation needs a walk over the list
    logic scan_done; // walk at its last step
  } dp_sts_t;

endpackage

>>> hw/rtl/bound_pruned_node_list.sv
// Bound-pruned node list: ordered store of up to DEPTH (key, handle) nodes.
// One input word carries func, key, handle and index; one result word is
// returned for each, with status, entry count, found entry and removed count.
// Both channels are valid/ready; one word is in flight at a time.
// Push, pop, read, clear and unused codes, and find min or erase that fail,
// go from the wait state straight to finish and then to the result state.
// Erase, prune and find min walk the stored entries through the single
// memory read port, one entry per cycle, in the walk state between the
// wait and finish states, ahead of the result state.
// Next word is accepted once the result has been taken.
// Reset empties the list; entry memory keeps its contents, and slots beyond
// the fill count may be read but are never used. A stalled receiver holds
// the result word stable and the block accepts nothing until it is taken.
// Depends on bpnl_pkg, bpnl_ctrl, bpnl_datapath.
module bound_pruned_node_list #(
  parameter int DEPTH = bpnl_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpnl_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bpnl_pkg::out_word_t out_data
);
  import bpnl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpnl_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  bpnl_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .in_word(in_data), .cmd, .sts, .out_word(out_data)
  );

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
endmodule

>>> hw/rtl/bpnl_datapath.sv
// Datapath: entry memory, fill count, scan pointers and result register.
// Depends on bpnl_pkg.
module bpnl_datapath #(
  parameter int DEPTH = bpnl_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bpnl_pkg::in_word_t  in_word,
  input  bpnl_pkg::dp_cmd_t   cmd,
  output bpnl_pkg::dp_sts_t   sts,
  output bpnl_pkg::out_word_t out_word
);
  import bpnl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] key_mem [DEPTH];
  logic [15:0]        hnd_mem [DEPTH];

  in_word_t op;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] rd_ptr, wr_ptr, removed;
  logic signed [31:0] best_key;
  logic [15:0]        best_hnd;
  logic [AW-1:0]      best_idx;
  logic               best_ok;

  // Memory read (registered) and write ports.
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_key;
  logic [15:0]        rd_hnd;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_key;
  logic [15:0]        wr_hnd;
  logic               rd_live;
  logic [AW-1:0]      rd_idx;

  // Flags captured at load for single-access operations.
  logic idx_hold_full, pop_ok, read_ok;
  logic signed [31:0] rd_key_hold;
  logic [15:0]        rd_hnd_hold;
  logic               hold_pend;

  logic idx_ok;
  logic erase_ok;
  assign idx_ok   = (32'(in_word.index) < 32'(fill_count));
  assign erase_ok = (32'(op.index) < 32'(fill_count));

  // Scan walks in order: rd_live tags the entry read last cycle.
  logic [CW-1:0] scan_end;
  assign scan_end = fill_count;

  always_comb begin
    sts.scan      = 1'b0;
    sts.scan_done = (rd_ptr == scan_end) && !rd_live;
    case (func_t'(op.func))
      FN_ERASE: sts.scan = erase_ok;
      FN_PRUNE: sts.scan = 1'b1;
      FN_MIN:   sts.scan = (fill_count != '0);
      default:  sts.scan = 1'b0;
    endcase
  end

  // Next read: pop/read target at load, else slot 0 until the walk starts.
  always_comb begin
    rd_addr = cmd.walk ? rd_ptr[AW-1:0] : '0;
    if (cmd.load) begin
      case (func_t'(in_word.func))
        FN_POP:   rd_addr = AW'(fill_count - CW'(1));
        FN_READ:  rd_addr = AW'(in_word.index);
        default:  rd_addr = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_hnd <= hnd_mem[rd_addr];
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      hnd_mem[wr_addr] <= wr_hnd;
    end
  end

  // Decide what a scanned entry does; a push writes its entry at load.
  logic keep;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_ptr[AW-1:0];
    wr_key  = rd_key;
    wr_hnd  = rd_hnd;
    keep    = 1'b1;
    if (cmd.load && func_t'(in_word.func) == FN_PUSH && fill_count < CW'(DEPTH)) begin
      wr_en   = 1'b1;
      wr_addr = fill_count[AW-1:0];
      wr_key  = in_word.key;
      wr_hnd  = in_word.handle;
    end else if (cmd.walk && rd_live) begin
      case (func_t'(op.func))
        FN_ERASE: keep = (rd_idx != AW'(op.index));
        FN_PRUNE: keep = (rd_key < $signed(op.key));
        default:  keep = 1'b1;
      endcase
      wr_en = keep && (func_t'(op.func) != FN_MIN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rd_live    <= 1'b0;
    end else if (cmd.load) begin
      op      <= in_word;
      rd_ptr  <= CW'(fill_count != '0);
      rd_idx  <= '0;
      rd_live <= (fill_count != '0);
      wr_ptr  <= '0;
      removed <= (func_t'(in_word.func) == FN_CLEAR) ? fill_count : '0;
      best_ok <= 1'b0;
      if (func_t'(in_word.func) == FN_PUSH && fill_count < CW'(DEPTH))
        fill_count <= fill_count + CW'(1);
      if (func_t'(in_word.func) == FN_POP && fill_count != '0)
        fill_count <= fill_count - CW'(1);
      if (func_t'(in_word.func) == FN_CLEAR)
        fill_count <= '0;
    end else if (cmd.walk) begin
      // Advance the read pointer; the last issued read is beyond the list.
      rd_live <= (rd_ptr < fill_count);
      rd_idx  <= rd_ptr[AW-1:0];
      if (rd_ptr < fill_count) rd_ptr <= rd_ptr + CW'(1);
      if (rd_live) begin
        if (wr_en) wr_ptr <= wr_ptr + CW'(1);
        if (!keep) removed <= removed + CW'(1);
        // Ties go to the later index: take on <=.
        if (!best_ok || rd_key <= best_key) begin
          best_key <= rd_key;
          best_hnd <= rd_hnd;
          best_idx <= rd_idx;
          best_ok  <= 1'b1;
        end
      end
    end else if (cmd.finish) begin
      if (func_t'(op.func) == FN_ERASE || func_t'(op.func) == FN_PRUNE)
        fill_count <= (sts.scan) ? wr_ptr : fill_count;
    end
  end

  // Result register; count written back on finish is reported here.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word <= '0;
      case (func_t'(op.func))
        FN_PUSH: begin
          out_word.status      <= (idx_hold_full) ? ST_FULL : ST_OK;
          out_word.entry_count <= 7'(fill_count);
        end
        FN_POP: begin
          if (pop_ok) begin
            out_word.found_key     <= rd_key_hold;
            out_word.found_handle  <= rd_hnd_hold;
            out_word.removed_count <= 7'd1;
          end else begin
            out_word.status <= ST_EMPTY;
          end
          out_word.entry_count <= 7'(fill_count);
        end
        FN_READ: begin
          if (read_ok) begin
            out_word.found_key    <= rd_key_hold;
            out_word.found_handle <= rd_hnd_hold;
          end else begin
            out_word.status <= ST_RANGE;
          end
          out_word.entry_count <= 7'(fill_count);
        end
        FN_ERASE: begin
          if (sts.scan) begin
            out_word.removed_count <= 7'd1;
            out_word.entry_count   <= 7'(wr_ptr);
          end else begin
            out_word.status      <= ST_RANGE;
            out_word.entry_count <= 7'(fill_count);
          end
        end
        FN_PRUNE: begin
          out_word.removed_count <= 7'(removed);
          out_word.entry_count   <= 7'(wr_ptr);
        end
        FN_MIN: begin
          if (sts.scan) begin
            out_word.found_key    <= best_key;
            out_word.found_handle <= best_hnd;
            out_word.found_index  <= 6'(best_idx);
          end else begin
            out_word.status <= ST_EMPTY;
          end
          out_word.entry_count <= 7'(fill_count);
        end
        FN_CLEAR: begin
          out_word.removed_count <= 7'(removed);
          out_word.entry_count   <= 7'(fill_count);
        end
        default: out_word.entry_count <= 7'(fill_count);
      endcase
    end
  end

  // Capture flags at load and the single read in the cycle after it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_hold_full <= !(fill_count < CW'(DEPTH));
      pop_ok        <= (fill_count != '0);
      read_ok       <= idx_ok;
    end
    hold_pend <= cmd.load;
    if (hold_pend) begin
      rd_key_hold <= rd_key;
      rd_hnd_hold <= rd_hnd;
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst) fill_count <= CW'(DEPTH))
    else $error("fill count above depth");
  a_ptr: assert property (@(posedge clk) disable iff (rst) cmd.walk |-> wr_ptr <= rd_ptr)
    else $error("write pointer passed read pointer");
  a_live: assert property (@(posedge clk) disable iff (rst)
    cmd.walk && rd_live |-> CW'(rd_idx) < fill_count)
    else $error("scanned entry beyond fill count");
endmodule

>>> hw/rtl/bpnl_ctrl.sv
// Controller: handshake and sequencing of load, walk and finish.
// Depends on bpnl_pkg.
module bpnl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bpnl_pkg::dp_sts_t sts,
  output bpnl_pkg::dp_cmd_t cmd
);
  import bpnl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WAIT = 5'b00010,
    S_WALK = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.walk   = (state == S_WALK);
  assign cmd.finish = (state == S_FIN);

  // Sequence one word at a time.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_WAIT;
      S_WAIT: state_next = sts.scan ? S_WALK : S_FIN;
      S_WALK: if (sts.scan_done) state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    $onehot({cmd.load, cmd.walk, cmd.finish}) || !(cmd.load || cmd.walk || cmd.finish))
    else $error("commands overlap");
  a_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finish without result");
endmodule

>>> tb/tb_top.sv
// Testbench for the bound-pruned node list: random and directed words, checked
// against a behavioral list model kept in a scoreboard class.
// Depends on bpnl_pkg and bound_pruned_node_list.
`timescale 1ns / 100ps

module tb_top;
  import bpnl_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  // Behavioral node list and queue of expected result words
  class node_list_board;
    logic signed [31:0] keys[$];
    logic [15:0]        handles[$];
    out_word_t          pending[$];
    int                 errors;

    function void note_word(in_word_t w);
      out_word_t r;
      int cnt, best;
      logic signed [31:0] kq[$];
      logic [15:0] hq[$];
      r = '0;
      r.status = ST_OK;
      cnt = keys.size();
      case (func_t'(w.func))
        FN_PUSH: begin
          if (cnt >= DEPTH) r.status = ST_FULL;
          else begin
            keys = {keys, w.key};
            handles = {handles, w.handle};
          end
        end
        FN_POP: begin
          if (cnt == 0) r.status = ST_EMPTY;
          else begin
            r.found_key = keys[cnt - 1];
            r.found_handle = handles[cnt - 1];
            keys.delete(cnt - 1);
            handles.delete(cnt - 1);
            r.removed_count = 7'd1;
          end
        end
        FN_READ: begin
          if (w.index >= cnt) r.status = ST_RANGE;
          else begin
            r.found_key = keys[w.index];
            r.found_handle = handles[w.index];
          end
        end
        FN_ERASE: begin
          if (w.index >= cnt) r.status = ST_RANGE;
          else begin
            keys.delete(w.index);
            handles.delete(w.index);
            r.removed_count = 7'd1;
          end
        end
        FN_PRUNE: begin
          for (int i = 0; i < cnt; i++) begin
            if (keys[i] >= $signed(w.key)) r.removed_count++;
            else begin
              kq = {kq, keys[i]};
              hq = {hq, handles[i]};
            end
          end
          keys = kq;
          handles = hq;
        end
        FN_MIN: begin
          if (cnt == 0) r.status = ST_EMPTY;
          else begin
            best = cnt - 1;
            for (int i = cnt - 1; i >= 0; i--)
              if (keys[i] < keys[best]) best = i;
            r.found_key = keys[best];
            r.found_handle = handles[best];
            r.found_index = 6'(best);
          end
        end
        FN_CLEAR: begin
          r.removed_count = 7'(cnt);
          keys.delete();
          handles.delete();
        end
        default: ;
      endcase
      r.entry_count = 7'(keys.size());
      pending = {pending, r};
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.entry_count !== e.entry_count ||
          got.found_key !== e.found_key || got.found_handle !== e.found_handle ||
          got.found_index !== e.found_index || got.removed_count !== e.removed_count)
      begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp st=%0d n=%0d k=%h h=%h i=%0d rm=%0d",
                    "  got st=%0d n=%0d k=%h h=%h i=%0d rm=%0d"},
                   e.status, e.entry_count, e.found_key, e.found_handle, e.found_index,
                   e.removed_count, got.status, got.entry_count, got.found_key,
                   got.found_handle, got.found_index, got.removed_count);
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_word_t out_data;
  bit        stim_done = 0;
  int        hold_off = 0;

  node_list_board board = new();

  bound_pruned_node_list #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  // Key mix: the two extremes, a narrow band that yields ties, and random keys
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return $signed($urandom_range(0, 7)) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word and hold it until accepted; drop valid only for a gap
  task automatic send_word(func_t f, logic signed [31:0] k, logic [15:0] h,
                           logic [5:0] ix);
    in_word_t w;
    int g;
    w.func = f;
    w.key = k;
    w.handle = h;
    w.index = ix;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(w);
  endtask

  task automatic send_random();
    int r, n;
    func_t f;
    n = board.keys.size();
    r = $urandom_range(0, 99);
    if (r < 40) f = FN_PUSH;
    else if (r < 50) f = FN_POP;
    else if (r < 62) f = FN_READ;
    else if (r < 72) f = FN_ERASE;
    else if (r < 80) f = FN_PRUNE;
    else if (r < 92) f = FN_MIN;
    else if (r < 95) f = FN_CLEAR;
    else f = FN_NOP;
    if (f == FN_PRUNE && n < 40 && $urandom_range(0, 1)) f = FN_PUSH;
    send_word(f, pick_key(), 16'($urandom),
              6'(($urandom_range(0, 3) == 0 || n == 0) ? $urandom
                                                        : $urandom_range(0, n - 1)));
  endtask

  // Stimulus: directed corner words, a fill to full, then random words
  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_word(FN_POP, 0, 0, 0);
    send_word(FN_MIN, 0, 0, 0);
    send_word(FN_READ, 0, 0, 0);
    send_word(FN_ERASE, 0, 0, 63);
    send_word(FN_PRUNE, 32'sh80000000, 0, 0);
    send_word(FN_CLEAR, 0, 0, 0);
    send_word(FN_NOP, 32'sh7fffffff, 16'hffff, 6'h3f);
    send_word(FN_PUSH, 32'sh80000000, 16'hffff, 0);
    send_word(FN_PUSH, 32'sh7fffffff, 16'h0000, 0);
    send_word(FN_PUSH, 32'sh80000000, 16'h1234, 0);
    send_word(FN_MIN, 0, 0, 0);
    send_word(FN_READ, 0, 0, 2);
    send_word(FN_READ, 0, 0, 3);
    send_word(FN_ERASE, 0, 0, 0);
    send_word(FN_PRUNE, 32'sh7fffffff, 0, 0);
    send_word(FN_PRUNE, 32'sh80000000, 0, 0);
    send_word(FN_POP, 0, 0, 0);
    // Fill while the receiver holds off so the block stalls its input
    hold_off = 150;
    for (int i = 0; i < DEPTH; i++) send_word(FN_PUSH, $urandom, 16'($urandom), 0);
    send_word(FN_PUSH, 0, 0, 0);
    send_word(FN_READ, 0, 0, 63);
    send_word(FN_MIN, 0, 0, 0);
    send_word(FN_CLEAR, 0, 0, 0);
    for (int i = 0; i < 820; i++) send_random();
    in_valid <= 0;
    stim_done = 1;
  end

  // Receiver: random ready with one long counted hold-off
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // Check each accepted result word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_word(out_data);
  end

  // Drain and report
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
